// File: src/gqg_pkg.sv
// Shared types, constants and helpers for the glyph quad generator.
`timescale 1ns / 1ps

package gqg_pkg;

    localparam int GLYPH_COUNT_DEF = 128;
    localparam int ATLAS_MAX_DEF   = 4096;

    localparam int CODE_W   = 7;
    localparam int COORD_W  = 12;
    localparam int ATLAS_W  = 13;
    localparam int SPACE_W  = 12;
    localparam int POS_W    = 16;
    localparam int TEX_W    = 17;
    localparam int FRAC_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int VIDX_W   = 3;

    localparam logic [CODE_W-1:0]  NEWLINE_CODE = 7'd10;
    localparam logic [VIDX_W-1:0]  LAST_VERT    = 3'd5;
    localparam logic [POS_W-1:0]   POS_MAX      = 16'hFFFF;
    localparam logic [TEX_W-1:0]   TEX_ONE      = 17'h10000;

    localparam logic [ATLAS_W-1:0] ATLAS_W_RST  = 13'd256;
    localparam logic [ATLAS_W-1:0] ATLAS_H_RST  = 13'd256;
    localparam logic [SPACE_W-1:0] LINE_SP_RST  = 12'd16;

    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_SPACING = 2'd2;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_PLACE = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] yo;
        logic [COORD_W-1:0] xo;
    } t_glyph;

    localparam int GLYPH_W = $bits(t_glyph);

    typedef struct packed {
        logic wr_glyph;
        logic capture;
        logic load;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic last_loaded;
    } t_dp_status;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_LOAD = 5'b00100,
        S_DIV  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    // Corners of the quad in the order (sx,sy) (ex,sy) (sx,ey) (ex,sy) (ex,ey) (sx,ey).
    function automatic logic corner_hi_x(input logic [VIDX_W-1:0] k);
        logic r;
        case (k)
            3'd1, 3'd3, 3'd4: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic corner_hi_y(input logic [VIDX_W-1:0] k);
        logic r;
        case (k)
            3'd2, 3'd4, 3'd5: r = 1'b1;
            default:          r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: src/gqg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module gqg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/gqg_div.sv
// Radix-4 restoring divider producing a saturated 1.16 texture coordinate.
`timescale 1ns / 1ps

module gqg_div #(
    parameter int DIV_W = 13
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DIV_W-1:0]         i_num,
    input  logic [DIV_W-1:0]         i_den,
    output logic                     o_busy,
    output logic [gqg_pkg::TEX_W-1:0] o_quot
);

    localparam int STEPS = gqg_pkg::FRAC_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic                        r_busy;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_sat;
    logic [DIV_W-1:0]            r_rem;
    logic [DIV_W-1:0]            r_den;
    logic [gqg_pkg::FRAC_W-1:0]  r_q;

    logic [DIV_W-1:0] n_rem;
    logic [1:0]       n_qb;
    logic [DIV_W:0]   t;

    always_comb begin
        n_rem = r_rem;
        n_qb  = 2'b00;
        t     = '0;
        for (int i = 0; i < 2; i++) begin
            t = {n_rem, 1'b0};
            if (t >= {1'b0, r_den}) begin
                n_rem      = DIV_W'(t - {1'b0, r_den});
                n_qb[1-i]  = 1'b1;
            end else begin
                n_rem = t[DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_sat  <= 1'b0;
        end else if (i_start) begin
            r_cnt <= '0;
            if (i_num >= i_den) begin
                r_sat  <= 1'b1;
                r_busy <= 1'b0;
            end else begin
                r_sat  <= 1'b0;
                r_busy <= 1'b1;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[gqg_pkg::FRAC_W-3:0], n_qb};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_sat ? gqg_pkg::TEX_ONE : {1'b0, r_q};

endmodule

// File: src/gqg_ctrl.sv
// Controller state machine sequencing table access, division and vertex output.
`timescale 1ns / 1ps

module gqg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_func,
    output logic                o_ready,
    output gqg_pkg::t_dp_cmd    o_cmd,
    input  gqg_pkg::t_dp_status i_status
);

    gqg_pkg::t_state r_state;
    gqg_pkg::t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            gqg_pkg::S_IDLE: begin
                o_ready          = 1'b1;
                o_cmd.wr_glyph   = i_valid && (i_func == gqg_pkg::FUNC_WRITE);
                o_cmd.capture    = i_valid && (i_func == gqg_pkg::FUNC_PLACE);
                if (o_cmd.capture) begin
                    n_state = gqg_pkg::S_READ;
                end
            end
            gqg_pkg::S_READ: begin
                n_state = gqg_pkg::S_LOAD;
            end
            gqg_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = gqg_pkg::S_DIV;
            end
            gqg_pkg::S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = gqg_pkg::S_EMIT;
                end
            end
            gqg_pkg::S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.last_loaded) begin
                    n_state = gqg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gqg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gqg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/gqg_datapath.sv
// Datapath: glyph table, pen, configuration registers, dividers and output beat register.
`timescale 1ns / 1ps

module gqg_datapath #(
    parameter int GLYPH_COUNT = gqg_pkg::GLYPH_COUNT_DEF,
    parameter int ATLAS_MAX   = gqg_pkg::ATLAS_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  gqg_pkg::t_dp_cmd                 i_cmd,
    output gqg_pkg::t_dp_status              o_status,
    input  logic [gqg_pkg::CODE_W-1:0]       i_code,
    input  logic                             i_first,
    input  gqg_pkg::t_glyph                  i_glyph,
    input  logic                             i_cfg_we,
    input  logic [gqg_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [gqg_pkg::ATLAS_W-1:0]      i_cfg_wdata,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [gqg_pkg::POS_W-1:0]        o_vertex_x,
    output logic [gqg_pkg::POS_W-1:0]        o_vertex_y,
    output logic [gqg_pkg::TEX_W-1:0]        o_tex_u,
    output logic [gqg_pkg::TEX_W-1:0]        o_tex_v,
    output logic                             o_last
);

    localparam int IDX_W = $clog2(GLYPH_COUNT);
    localparam int AM_W  = $clog2(ATLAS_MAX + 1);
    localparam int DIV_W = (AM_W > gqg_pkg::ATLAS_W) ? AM_W : gqg_pkg::ATLAS_W;

    logic [gqg_pkg::ATLAS_W-1:0] r_atlas_w;
    logic [gqg_pkg::ATLAS_W-1:0] r_atlas_h;
    logic [gqg_pkg::SPACE_W-1:0] r_line_sp;

    logic [GLYPH_COUNT-1:0]      r_valid;
    logic                        r_rd_valid;
    logic [gqg_pkg::CODE_W-1:0]  r_code;
    logic                        r_first;
    logic [gqg_pkg::POS_W-1:0]   r_pen_x;
    logic [gqg_pkg::POS_W-1:0]   r_pen_y;
    logic [gqg_pkg::POS_W-1:0]   r_sx;
    logic [gqg_pkg::POS_W-1:0]   r_sy;
    logic [gqg_pkg::POS_W-1:0]   r_ex;
    logic [gqg_pkg::POS_W-1:0]   r_ey;
    logic [gqg_pkg::VIDX_W-1:0]  r_vidx;

    logic                        r_out_valid;
    logic [gqg_pkg::POS_W-1:0]   r_out_x;
    logic [gqg_pkg::POS_W-1:0]   r_out_y;
    logic [gqg_pkg::TEX_W-1:0]   r_out_u;
    logic [gqg_pkg::TEX_W-1:0]   r_out_v;
    logic                        r_out_last;

    logic [gqg_pkg::GLYPH_W-1:0] rdata;
    gqg_pkg::t_glyph             g;
    logic [IDX_W-1:0]            waddr;
    logic [IDX_W-1:0]            raddr;
    logic [gqg_pkg::POS_W-1:0]   start_x;
    logic [gqg_pkg::POS_W-1:0]   start_y;
    logic [gqg_pkg::POS_W:0]     sum_x;
    logic [gqg_pkg::POS_W:0]     sum_y;
    logic [gqg_pkg::POS_W:0]     sum_nl;
    logic [gqg_pkg::POS_W-1:0]   end_x;
    logic [gqg_pkg::POS_W-1:0]   end_y;
    logic [DIV_W-1:0]            den_w;
    logic [DIV_W-1:0]            den_h;
    logic [DIV_W-1:0]            num_u0;
    logic [DIV_W-1:0]            num_u1;
    logic [DIV_W-1:0]            num_v0;
    logic [DIV_W-1:0]            num_v1;
    logic [3:0]                  busy;
    logic [gqg_pkg::TEX_W-1:0]   q_u0;
    logic [gqg_pkg::TEX_W-1:0]   q_u1;
    logic [gqg_pkg::TEX_W-1:0]   q_v0;
    logic [gqg_pkg::TEX_W-1:0]   q_v1;
    logic                        out_free;
    logic                        beat_load;
    logic                        last_load;
    logic                        hi_x;
    logic                        hi_y;

    assign waddr = IDX_W'(i_code);
    assign raddr = IDX_W'(r_code);

    gqg_ram #(
        .WIDTH (gqg_pkg::GLYPH_W),
        .DEPTH (GLYPH_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_glyph),
        .i_waddr (waddr),
        .i_wdata (i_glyph),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_w <= gqg_pkg::ATLAS_W_RST;
            r_atlas_h <= gqg_pkg::ATLAS_H_RST;
            r_line_sp <= gqg_pkg::LINE_SP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                gqg_pkg::REG_ATLAS_WIDTH:  r_atlas_w <= i_cfg_wdata;
                gqg_pkg::REG_ATLAS_HEIGHT: r_atlas_h <= i_cfg_wdata;
                gqg_pkg::REG_LINE_SPACING: r_line_sp <= i_cfg_wdata[gqg_pkg::SPACE_W-1:0];
                default: ;
            endcase
        end
    end

    // Entries never written read as an all-zero glyph.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.wr_glyph) begin
            r_valid[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[raddr];
    end

    assign g = r_rd_valid ? gqg_pkg::t_glyph'(rdata) : '0;

    always_comb begin
        den_w = DIV_W'(r_atlas_w);
        if (r_atlas_w == '0) begin
            den_w = DIV_W'(1);
        end else if (DIV_W'(r_atlas_w) > DIV_W'(ATLAS_MAX)) begin
            den_w = DIV_W'(ATLAS_MAX);
        end
        den_h = DIV_W'(r_atlas_h);
        if (r_atlas_h == '0) begin
            den_h = DIV_W'(1);
        end else if (DIV_W'(r_atlas_h) > DIV_W'(ATLAS_MAX)) begin
            den_h = DIV_W'(ATLAS_MAX);
        end
    end

    assign num_u0 = DIV_W'(g.xo);
    assign num_u1 = DIV_W'({1'b0, g.xo} + {1'b0, g.w});
    assign num_v0 = DIV_W'(g.yo);
    assign num_v1 = DIV_W'({1'b0, g.yo} + {1'b0, g.h});

    gqg_div #(.DIV_W(DIV_W)) u_div_u0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.load),
        .i_num(num_u0), .i_den(den_w), .o_busy(busy[0]), .o_quot(q_u0)
    );
    gqg_div #(.DIV_W(DIV_W)) u_div_u1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.load),
        .i_num(num_u1), .i_den(den_w), .o_busy(busy[1]), .o_quot(q_u1)
    );
    gqg_div #(.DIV_W(DIV_W)) u_div_v0 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.load),
        .i_num(num_v0), .i_den(den_h), .o_busy(busy[2]), .o_quot(q_v0)
    );
    gqg_div #(.DIV_W(DIV_W)) u_div_v1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.load),
        .i_num(num_v1), .i_den(den_h), .o_busy(busy[3]), .o_quot(q_v1)
    );

    assign start_x = r_first ? '0 : r_pen_x;
    assign start_y = r_first ? '0 : r_pen_y;
    assign sum_x   = {1'b0, start_x} + (gqg_pkg::POS_W + 1)'(g.w);
    assign sum_y   = {1'b0, start_y} + (gqg_pkg::POS_W + 1)'(g.h);
    assign end_x   = sum_x[gqg_pkg::POS_W] ? gqg_pkg::POS_MAX : sum_x[gqg_pkg::POS_W-1:0];
    assign end_y   = sum_y[gqg_pkg::POS_W] ? gqg_pkg::POS_MAX : sum_y[gqg_pkg::POS_W-1:0];
    assign sum_nl  = {1'b0, r_sy} + (gqg_pkg::POS_W + 1)'(r_line_sp);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_code  <= i_code;
            r_first <= i_first;
        end
        if (i_cmd.load) begin
            r_sx <= start_x;
            r_sy <= start_y;
            r_ex <= end_x;
            r_ey <= end_y;
        end
    end

    assign out_free  = !r_out_valid || i_ready;
    assign beat_load = i_cmd.emit && out_free;
    assign last_load = beat_load && (r_vidx == gqg_pkg::LAST_VERT);
    assign hi_x      = gqg_pkg::corner_hi_x(r_vidx);
    assign hi_y      = gqg_pkg::corner_hi_y(r_vidx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_vidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (beat_load) begin
                r_out_valid <= 1'b1;
                r_vidx      <= last_load ? '0 : r_vidx + 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (last_load) begin
                if (r_code == gqg_pkg::NEWLINE_CODE) begin
                    r_pen_x <= '0;
                    r_pen_y <= sum_nl[gqg_pkg::POS_W] ? gqg_pkg::POS_MAX
                                                      : sum_nl[gqg_pkg::POS_W-1:0];
                end else begin
                    r_pen_x <= r_ex;
                    r_pen_y <= r_sy;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (beat_load) begin
            r_out_x    <= hi_x ? r_ex : r_sx;
            r_out_y    <= hi_y ? r_ey : r_sy;
            r_out_u    <= hi_x ? q_u1 : q_u0;
            r_out_v    <= hi_y ? q_v1 : q_v0;
            r_out_last <= (r_vidx == gqg_pkg::LAST_VERT);
        end
    end

    assign o_status.div_busy    = |busy;
    assign o_status.last_loaded = last_load;

    assign o_valid    = r_out_valid;
    assign o_vertex_x = r_out_x;
    assign o_vertex_y = r_out_y;
    assign o_tex_u    = r_out_u;
    assign o_tex_v    = r_out_v;
    assign o_last     = r_out_last;

    a_emit_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !(|busy))
        else $error("vertex emitted while a divider is still running");

    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_load |=> (r_vidx == '0) && r_out_valid && r_out_last)
        else $error("sixth vertex did not close the quad");

    a_tex_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_u <= gqg_pkg::TEX_ONE) && (r_out_v <= gqg_pkg::TEX_ONE))
        else $error("texture coordinate above 1.0");

endmodule

// File: src/glyph_quad_generator.sv
// Top level of the glyph quad generator: stream ports, controller and datapath.
`timescale 1ns / 1ps

// A write beat (tuser 0) loads one glyph table entry and yields no output.
// A place beat (tuser 1) yields six vertex beats, tlast on the sixth: the
// beat is accepted, the glyph table is read, the quad is set up, four
// parallel dividers produce two quotient bits per cycle (no division runs
// when all four texture coordinates saturate), and the six output beats
// follow. The next beat is accepted as soon as the sixth vertex sits in the
// output register.
// Texture coordinates are floor(n * 65536 / atlas) saturated at 1.0, and
// positions saturate at 65535. The glyph table reads as zero after reset,
// so an unloaded glyph gives a zero-size quad.
module glyph_quad_generator #(
    parameter int GLYPH_COUNT = gqg_pkg::GLYPH_COUNT_DEF,
    parameter int ATLAS_MAX   = gqg_pkg::ATLAS_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // code[6:0], first[7], glyph_x_offset[19:8], glyph_y_offset[31:20],
    // glyph_width[43:32], glyph_height[55:44]
    input  logic [55:0]                   s_axis_tdata,
    // func[0]
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // vertex_x[15:0], vertex_y[31:16], tex_u[48:32], tex_v[65:49], zeros[71:66]
    output logic [71:0]                   m_axis_tdata,
    output logic                          m_axis_tlast,
    input  logic                          i_cfg_we,
    input  logic [gqg_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [gqg_pkg::ATLAS_W-1:0]   i_cfg_wdata
);

    gqg_pkg::t_dp_cmd    cmd;
    gqg_pkg::t_dp_status status;
    gqg_pkg::t_glyph     glyph;

    logic [gqg_pkg::POS_W-1:0] vx;
    logic [gqg_pkg::POS_W-1:0] vy;
    logic [gqg_pkg::TEX_W-1:0] tu;
    logic [gqg_pkg::TEX_W-1:0] tv;

    assign glyph.xo = s_axis_tdata[19:8];
    assign glyph.yo = s_axis_tdata[31:20];
    assign glyph.w  = s_axis_tdata[43:32];
    assign glyph.h  = s_axis_tdata[55:44];

    gqg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_func   (s_axis_tuser),
        .o_ready  (s_axis_tready),
        .o_cmd    (cmd),
        .i_status (status)
    );

    gqg_datapath #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .ATLAS_MAX   (ATLAS_MAX)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_code      (s_axis_tdata[6:0]),
        .i_first     (s_axis_tdata[7]),
        .i_glyph     (glyph),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_vertex_x  (vx),
        .o_vertex_y  (vy),
        .o_tex_u     (tu),
        .o_tex_v     (tv),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, tv, tu, vy, vx};

endmodule

// File: sim/tb_glyph_quad_generator.sv
// Self-checking testbench for the glyph quad generator with a built-in layout predictor.
`timescale 1ns / 1ps

module tb_glyph_quad_generator;

    typedef struct packed {
        logic                        func;
        logic [gqg_pkg::CODE_W-1:0]  code;
        logic                        first;
        logic [gqg_pkg::COORD_W-1:0] xo;
        logic [gqg_pkg::COORD_W-1:0] yo;
        logic [gqg_pkg::COORD_W-1:0] w;
        logic [gqg_pkg::COORD_W-1:0] h;
    } t_char_beat;

    typedef struct packed {
        logic [gqg_pkg::POS_W-1:0] x;
        logic [gqg_pkg::POS_W-1:0] y;
        logic [gqg_pkg::TEX_W-1:0] u;
        logic [gqg_pkg::TEX_W-1:0] v;
        logic                      is_last;
    } t_vertex;

    class quad_scoreboard;
        gqg_pkg::t_glyph             glyphs[gqg_pkg::GLYPH_COUNT_DEF];
        logic [gqg_pkg::POS_W-1:0]   pen_x;
        logic [gqg_pkg::POS_W-1:0]   pen_y;
        logic [gqg_pkg::ATLAS_W-1:0] atlas_w;
        logic [gqg_pkg::ATLAS_W-1:0] atlas_h;
        logic [gqg_pkg::SPACE_W-1:0] line_sp;
        t_vertex                     pending_verts[$];
        int                          errors;
        int                          verts_seen;
        int                          glyph_loads;
        int                          chars_placed;
        int                          newlines;
        int                          pos_clips;
        int                          tex_clips;

        function new();
            foreach (glyphs[i]) glyphs[i] = '0;
            pen_x = '0;
            pen_y = '0;
            atlas_w = gqg_pkg::ATLAS_W_RST;
            atlas_h = gqg_pkg::ATLAS_H_RST;
            line_sp = gqg_pkg::LINE_SP_RST;
            errors = 0;
            verts_seen = 0;
            glyph_loads = 0;
            chars_placed = 0;
            newlines = 0;
            pos_clips = 0;
            tex_clips = 0;
        endfunction

        function void set_reg(logic [gqg_pkg::CFG_IDX_W-1:0] idx,
                              logic [gqg_pkg::ATLAS_W-1:0] val);
            case (idx)
                gqg_pkg::REG_ATLAS_WIDTH:  atlas_w = val;
                gqg_pkg::REG_ATLAS_HEIGHT: atlas_h = val;
                gqg_pkg::REG_LINE_SPACING: line_sp = val[gqg_pkg::SPACE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [gqg_pkg::POS_W-1:0] clip_pos(logic [gqg_pkg::POS_W-1:0] a,
                                                     logic [gqg_pkg::POS_W-1:0] b);
            logic [gqg_pkg::POS_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (s > {1'b0, gqg_pkg::POS_MAX}) begin
                pos_clips++;
                return gqg_pkg::POS_MAX;
            end
            return s[gqg_pkg::POS_W-1:0];
        endfunction

        function logic [gqg_pkg::TEX_W-1:0] tex_frac(logic [gqg_pkg::COORD_W-1:0] base,
                                                     logic [gqg_pkg::COORD_W-1:0] span,
                                                     logic [gqg_pkg::ATLAS_W-1:0] atlas);
            logic [31:0] num;
            logic [31:0] den;
            logic [31:0] q;
            num = ({20'b0, base} + {20'b0, span}) << gqg_pkg::FRAC_W;
            if (atlas == '0)
                den = 32'd1;
            else if (atlas > gqg_pkg::ATLAS_MAX_DEF)
                den = 32'(gqg_pkg::ATLAS_MAX_DEF);
            else
                den = {19'b0, atlas};
            q = num / den;
            if (q > {15'b0, gqg_pkg::TEX_ONE}) begin
                tex_clips++;
                return gqg_pkg::TEX_ONE;
            end
            return q[gqg_pkg::TEX_W-1:0];
        endfunction

        function void note_beat(t_char_beat b);
            gqg_pkg::t_glyph           g;
            logic [gqg_pkg::POS_W-1:0] sx, sy, ex, ey;
            logic [gqg_pkg::TEX_W-1:0] u0, u1, v0, v1;
            logic [gqg_pkg::VIDX_W-1:0] kv;
            t_vertex                   vt;
            if (b.func == gqg_pkg::FUNC_WRITE) begin
                g.xo = b.xo;
                g.yo = b.yo;
                g.w = b.w;
                g.h = b.h;
                glyphs[b.code] = g;
                glyph_loads++;
                return;
            end
            chars_placed++;
            if (b.first) begin
                pen_x = '0;
                pen_y = '0;
            end
            g = glyphs[b.code];
            sx = pen_x;
            sy = pen_y;
            ex = clip_pos(sx, {4'b0, g.w});
            ey = clip_pos(sy, {4'b0, g.h});
            u0 = tex_frac(g.xo, '0, atlas_w);
            u1 = tex_frac(g.xo, g.w, atlas_w);
            v0 = tex_frac(g.yo, '0, atlas_h);
            v1 = tex_frac(g.yo, g.h, atlas_h);
            for (int k = 0; k < 6; k++) begin
                kv = gqg_pkg::VIDX_W'(k);
                vt.x = gqg_pkg::corner_hi_x(kv) ? ex : sx;
                vt.y = gqg_pkg::corner_hi_y(kv) ? ey : sy;
                vt.u = gqg_pkg::corner_hi_x(kv) ? u1 : u0;
                vt.v = gqg_pkg::corner_hi_y(kv) ? v1 : v0;
                vt.is_last = (kv == gqg_pkg::LAST_VERT);
                pending_verts.push_back(vt);
            end
            pen_x = ex;
            if (b.code == gqg_pkg::NEWLINE_CODE) begin
                newlines++;
                pen_x = '0;
                pen_y = clip_pos(pen_y, {4'b0, line_sp});
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50)
                $display("ERROR at %0t: %s", $realtime, msg);
        endtask

        task check_vertex(t_vertex got);
            t_vertex want;
            verts_seen++;
            if (pending_verts.size() == 0) begin
                report($sformatf("vertex %0d arrived with none expected", verts_seen));
                return;
            end
            want = pending_verts.pop_front();
            if (got.x !== want.x)
                report($sformatf("vertex %0d x: got %0d, want %0d", verts_seen, got.x, want.x));
            if (got.y !== want.y)
                report($sformatf("vertex %0d y: got %0d, want %0d", verts_seen, got.y, want.y));
            if (got.u !== want.u)
                report($sformatf("vertex %0d u: got %0h, want %0h", verts_seen, got.u, want.u));
            if (got.v !== want.v)
                report($sformatf("vertex %0d v: got %0h, want %0h", verts_seen, got.v, want.v));
            if (got.is_last !== want.is_last)
                report($sformatf("vertex %0d last: got %0b, want %0b", verts_seen,
                                 got.is_last, want.is_last));
        endtask
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [55:0]                   s_axis_tdata;
    logic                          s_axis_tuser;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [71:0]                   m_axis_tdata;
    logic                          m_axis_tlast;
    logic                          i_cfg_we;
    logic [gqg_pkg::CFG_IDX_W-1:0] i_cfg_addr;
    logic [gqg_pkg::ATLAS_W-1:0]   i_cfg_wdata;

    quad_scoreboard             sb = new();
    bit                         src_idle_en;
    bit                         sink_idle_en;
    int                         settings_used;
    logic [gqg_pkg::CODE_W-1:0] loaded_codes[$];

    glyph_quad_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    initial begin
        #4_000_000;
        $display("Timeout: the run did not drain in time");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Output side: checks every accepted vertex beat and applies back-pressure.
    initial begin
        t_vertex got;
        int      stall_left;
        int      hold_left;
        bit      held;
        stall_left = 0;
        hold_left = 0;
        held = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.x = m_axis_tdata[15:0];
                got.y = m_axis_tdata[31:16];
                got.u = m_axis_tdata[48:32];
                got.v = m_axis_tdata[65:49];
                got.is_last = m_axis_tlast;
                sb.check_vertex(got);
            end
            @(negedge i_clk);
            // One long hold-off so the block backs up and stalls its input.
            if (!held && sb.verts_seen >= 48) begin
                held = 1'b1;
                hold_left = 300;
            end
            if (stall_left == 0 && sink_idle_en && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 18);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    task automatic push_beat(t_char_beat b);
        int gap;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = b.func;
        s_axis_tdata = {b.h, b.w, b.yo, b.xo, b.first, b.code};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_beat(b);
    endtask

    task automatic load_glyph(logic [gqg_pkg::CODE_W-1:0] code, logic first,
                              logic [gqg_pkg::COORD_W-1:0] xo,
                              logic [gqg_pkg::COORD_W-1:0] yo,
                              logic [gqg_pkg::COORD_W-1:0] w,
                              logic [gqg_pkg::COORD_W-1:0] h);
        t_char_beat b;
        b.func = gqg_pkg::FUNC_WRITE;
        b.code = code;
        b.first = first;
        b.xo = xo;
        b.yo = yo;
        b.w = w;
        b.h = h;
        push_beat(b);
    endtask

    task automatic place_char(logic [gqg_pkg::CODE_W-1:0] code, logic first);
        t_char_beat b;
        b.func = gqg_pkg::FUNC_PLACE;
        b.code = code;
        b.first = first;
        // The glyph fields are ignored on a place beat, so they carry noise.
        b.xo = gqg_pkg::COORD_W'($urandom_range(0, 4095));
        b.yo = gqg_pkg::COORD_W'($urandom_range(0, 4095));
        b.w = gqg_pkg::COORD_W'($urandom_range(0, 4095));
        b.h = gqg_pkg::COORD_W'($urandom_range(0, 4095));
        push_beat(b);
    endtask

    // Waits until every expected vertex has arrived and the block has gone quiet.
    task automatic wait_quiet();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_verts.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [gqg_pkg::CFG_IDX_W-1:0] idx,
                             logic [gqg_pkg::ATLAS_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic apply_settings(logic [gqg_pkg::ATLAS_W-1:0] aw,
                                  logic [gqg_pkg::ATLAS_W-1:0] ah,
                                  logic [gqg_pkg::SPACE_W-1:0] ls);
        wait_quiet();
        write_reg(gqg_pkg::REG_ATLAS_WIDTH, aw);
        write_reg(gqg_pkg::REG_ATLAS_HEIGHT, ah);
        write_reg(gqg_pkg::REG_LINE_SPACING, {1'b0, ls});
        settings_used++;
    endtask

    function automatic logic [gqg_pkg::ATLAS_W-1:0] pick_atlas();
        case ($urandom_range(0, 4))
            0: return gqg_pkg::ATLAS_W'($urandom_range(1, 16));
            1: return gqg_pkg::ATLAS_W'(gqg_pkg::ATLAS_MAX_DEF);
            2: begin
                if ($urandom_range(0, 1) != 0)
                    return '0;
                return gqg_pkg::ATLAS_W'($urandom_range(gqg_pkg::ATLAS_MAX_DEF + 1, 8191));
            end
            default: return gqg_pkg::ATLAS_W'($urandom_range(1, gqg_pkg::ATLAS_MAX_DEF));
        endcase
    endfunction

    function automatic logic [gqg_pkg::CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return gqg_pkg::NEWLINE_CODE;
        if (r < 8 && loaded_codes.size() > 0)
            return loaded_codes[$urandom_range(0, loaded_codes.size() - 1)];
        return gqg_pkg::CODE_W'($urandom_range(0, 127));
    endfunction

    task automatic random_glyph_load();
        logic [gqg_pkg::CODE_W-1:0]  code;
        logic [gqg_pkg::COORD_W-1:0] w;
        logic [gqg_pkg::COORD_W-1:0] h;
        code = ($urandom_range(0, 1) != 0) ? pick_code()
                                           : gqg_pkg::CODE_W'($urandom_range(0, 127));
        w = ($urandom_range(0, 2) == 0) ? gqg_pkg::COORD_W'($urandom_range(0, 4095))
                                        : gqg_pkg::COORD_W'($urandom_range(0, 63));
        h = ($urandom_range(0, 2) == 0) ? gqg_pkg::COORD_W'($urandom_range(0, 4095))
                                        : gqg_pkg::COORD_W'($urandom_range(0, 63));
        load_glyph(code, 1'($urandom_range(0, 1)),
                   gqg_pkg::COORD_W'($urandom_range(0, 4095)),
                   gqg_pkg::COORD_W'($urandom_range(0, 4095)), w, h);
        loaded_codes.push_back(code);
        if (loaded_codes.size() > 8)
            void'(loaded_codes.pop_front());
    endtask

    // Mostly runs of text, some starting on a fresh pen, mixed with glyph loads.
    task automatic random_traffic(int n_beats, bit allow_idle);
        int done;
        int len;
        done = 0;
        while (done < n_beats) begin
            src_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            sink_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) begin
                random_glyph_load();
                done++;
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
                for (int j = 0; j < len && done < n_beats; j++) begin
                    if (j == 0)
                        place_char(pick_code(), $urandom_range(0, 3) == 0);
                    else
                        place_char(pick_code(), $urandom_range(0, 15) == 0);
                    done++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = gqg_pkg::FUNC_WRITE;
        i_cfg_we = 1'b0;
        i_cfg_addr = gqg_pkg::REG_ATLAS_WIDTH;
        i_cfg_wdata = '0;
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        settings_used = 1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: an unloaded glyph first, then loaded ones and newlines.
        place_char(7'd65, 1'b0);
        load_glyph(7'd65, 1'b1, 12'd100, 12'd200, 12'd10, 12'd14);
        load_glyph(gqg_pkg::NEWLINE_CODE, 1'b0, 12'd16, 12'd32, 12'd8, 12'd12);
        load_glyph(7'd127, 1'b0, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        load_glyph(7'd0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0);
        place_char(7'd65, 1'b1);
        place_char(7'd65, 1'b0);
        place_char(gqg_pkg::NEWLINE_CODE, 1'b0);
        place_char(7'd65, 1'b0);
        place_char(7'd0, 1'b0);
        place_char(7'd127, 1'b0);
        place_char(7'd127, 1'b0);
        place_char(gqg_pkg::NEWLINE_CODE, 1'b0);

        // Smallest atlas width, largest atlas height, no line spacing.
        apply_settings(13'd1, gqg_pkg::ATLAS_W'(gqg_pkg::ATLAS_MAX_DEF), 12'd0);
        place_char(7'd65, 1'b1);
        place_char(gqg_pkg::NEWLINE_CODE, 1'b0);
        place_char(7'd127, 1'b0);

        // Atlas sizes outside the legal range and the largest line spacing.
        apply_settings(13'd0, 13'd8191, 12'd4095);
        load_glyph(7'd1, 1'b0, 12'd0, 12'd0, 12'd4095, 12'd4095);
        place_char(7'd1, 1'b1);
        place_char(gqg_pkg::NEWLINE_CODE, 1'b0);
        place_char(gqg_pkg::NEWLINE_CODE, 1'b0);

        loaded_codes.push_back(7'd65);
        loaded_codes.push_back(7'd127);
        loaded_codes.push_back(7'd1);
        random_traffic(60, 1'b1);

        for (int p = 0; p < 3; p++) begin
            apply_settings(pick_atlas(), pick_atlas(),
                           ($urandom_range(0, 2) == 0) ? 12'd4095
                               : gqg_pkg::SPACE_W'($urandom_range(0, 4095)));
            random_traffic(50, 1'b1);
        end

        apply_settings(13'd4097, 13'd1, gqg_pkg::SPACE_W'($urandom_range(0, 64)));
        random_traffic(45, 1'b0);

        wait_quiet();
        while (sb.pending_verts.size() != 0) begin
            sb.report("expected vertex never arrived");
            void'(sb.pending_verts.pop_front());
        end
        $display("Covered %0d glyph loads and %0d placed characters (%0d newlines) under %0d settings.",
                 sb.glyph_loads, sb.chars_placed, sb.newlines, settings_used);
        $display("Checked %0d vertices; %0d position clips and %0d texture clips were predicted.",
                 sb.verts_seen, sb.pos_clips, sb.tex_clips);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
